FILE: hdl/snw_pkg.sv
// ============================================================================
// snw_pkg: shared types and constants of the nine-bit word packer
// Holds the item kinds, the opening byte of a data transfer and the
// record that carries the packed bytes of one item to the output stage.
// ============================================================================
package snw_pkg;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // A data transfer opens with a single 1 bit in the MSB.
    localparam logic [7:0] OPEN_BYTE = 8'h80;
    localparam logic [2:0] OPEN_FILL = 3'd1;
    localparam logic [2:0] FULL_FILL = 3'd7;

    // Packed bytes produced by one item: one or two beats.
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       two_beats;
        logic       eot;          // the final beat of the pair ends the transaction
    } snw_pair_t;

endpackage

FILE: hdl/snw_if.sv
// ============================================================================
// snw_if: valid/ready channels of the nine-bit word packer
// One interface for input items and one for packed result beats.
// ============================================================================
interface snw_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

interface snw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       end_of_transaction;

    modport source (output valid, output wire_byte, output end_of_transaction, input ready);
    modport sink   (input valid, input wire_byte, input end_of_transaction, output ready);
endinterface

FILE: hdl/snw_packer.sv
// ============================================================================
// snw_packer: bit packing and transfer state
// Merges one nine-bit data word into the open partial byte or packs a
// command alone; keeps the partial byte, fill count and open-transfer flag.
// ============================================================================
module snw_packer
    import snw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic       kind,
    input  logic [7:0] value,
    input  logic       last,
    output snw_pair_t  pair
);

    logic [7:0]  partial_reg, partial_next;
    logic [2:0]  fill_reg, fill_next;
    logic        open_reg, open_next;

    logic [7:0]  base_byte;
    logic [2:0]  base_fill;
    logic [15:0] merged;
    logic        fills_two;

    always_comb
    begin
        base_byte = open_reg ? partial_reg : OPEN_BYTE;
        base_fill = open_reg ? fill_reg : OPEN_FILL;
        // place data bits then the marker bit right after the held bits
        merged    = {base_byte, 8'h00} | ({value, 1'b1, 7'b000_0000} >> base_fill);
        fills_two = (base_fill == FULL_FILL);

        partial_next = partial_reg;
        fill_next    = fill_reg;
        open_next    = open_reg;

        unique case (kind)
            KIND_CMD:
            begin
                pair.first_byte  = {1'b0, value[7:1]};
                pair.second_byte = {value[0], 7'b000_0000};
                pair.two_beats   = 1'b1;
                pair.eot         = 1'b1;
                partial_next     = 8'h00;
                fill_next        = 3'd0;
                open_next        = 1'b0;
            end
            default:
            begin
                pair.first_byte  = merged[15:8];
                pair.second_byte = merged[7:0];
                pair.two_beats   = fills_two | last;
                pair.eot         = last;
                if (fills_two || last)
                begin
                    partial_next = 8'h00;
                    fill_next    = 3'd0;
                end
                else
                begin
                    partial_next = merged[7:0];
                    fill_next    = base_fill + 3'd1;
                end
                open_next = ~last;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 8'h00;
            fill_reg    <= 3'd0;
            open_reg    <= 1'b0;
        end
        else if (fire)
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
            open_reg    <= open_next;
        end
    end

    // closed transfer leaves nothing behind
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> (fill_reg == 3'd0) && (partial_reg == 8'h00))
        else $error("closed transfer holds partial bits");

    a_cmd_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (kind == KIND_CMD) |=> !open_reg)
        else $error("command left a transfer open");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (kind == KIND_DATA) && last |=> !open_reg)
        else $error("last data byte left a transfer open");

endmodule

FILE: hdl/snw_out_buf.sv
// ============================================================================
// snw_out_buf: result register and beat serializer
// Holds the packed bytes of one item and hands them out one beat per cycle while results.ready is high.
// ============================================================================
module snw_out_buf
    import snw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  snw_pair_t pair_in,
    output logic      can_load,
    snw_out_if.source results
);

    snw_pair_t pair_reg;
    logic      valid_reg, valid_next;
    logic      second_reg, second_next;

    logic      beat_fire;
    logic      final_beat;

    assign final_beat = second_reg | ~pair_reg.two_beats;
    assign beat_fire  = valid_reg & results.ready;
    assign can_load   = ~valid_reg | (beat_fire & final_beat);

    assign results.valid              = valid_reg;
    assign results.wire_byte          = second_reg ? pair_reg.second_byte : pair_reg.first_byte;
    assign results.end_of_transaction = final_beat & pair_reg.eot;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        priority if (load)
        begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end
        else if (beat_fire && final_beat)
        begin
            valid_next  = 1'b0;
            second_next = 1'b0;
        end
        else if (beat_fire)
        begin
            second_next = 1'b1;
        end
        else
        begin
            // hold the pending beat
            valid_next  = valid_reg;
            second_next = second_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pair_reg <= pair_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> valid_reg && pair_reg.two_beats)
        else $error("second beat selected without a two-beat pair");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        beat_fire && !final_beat && !load |=> valid_reg && second_reg)
        else $error("second beat lost after first beat");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("pending beats overwritten");

endmodule

FILE: hdl/spi_nine_bit_word_packer.sv
// ============================================================================
// spi_nine_bit_word_packer: byte packer for a 3-wire SPI link
// Packs command and data bytes, each sent as a nine-bit word, into an
// MSB-first byte stream and flags the last byte of every transaction.
// ============================================================================
// Timing: the first beat of an item is valid in the cycle after its accept.
// Throughput: one beat per cycle while results.ready is high; an item yields
//   one beat, or two beats (commands, last data bytes, the 7th data byte
//   of a transfer and every 8th after it), sent in turn through the single
//   output port.
// Reset: rst_n clears the open transfer, fill count and pending beats.
// ============================================================================
module spi_nine_bit_word_packer
    import snw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    snw_in_if.sink    items,
    snw_out_if.source results
);

    snw_pair_t pair;
    logic      can_load;
    logic      item_fire;

    // Take a new item whenever the result register is empty or its final
    // beat leaves in this same cycle.
    assign items.ready = can_load;
    assign item_fire   = items.valid & can_load;

    // Merge the nine-bit word into the transfer state; commands bypass it
    // and drop any open partial byte.
    snw_packer u_packer (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (item_fire),
        .kind  (items.kind),
        .value (items.value),
        .last  (items.last),
        .pair  (pair)
    );

    // Hold the packed bytes and hand them out one beat at a time.
    snw_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (item_fire),
        .pair_in  (pair),
        .can_load (can_load),
        .results  (results)
    );

endmodule
